// ----- design/pdenc_pkg.sv -----
// shared types, constants and the divide-by-five step for the psg dump encoder
// no dependencies
package pdenc_pkg;

    localparam logic [7:0]  RegLimit       = 8'd18;
    localparam logic [31:0] PauseThreshold = 32'd10;
    localparam logic [7:0]  SelectReset    = 8'hFF;
    localparam logic [7:0]  IntrReset      = 8'hFF;
    localparam logic [7:0]  SkipReset      = 8'hFE;
    localparam int          QueueDepth     = 2;
    localparam int          DivSteps       = 4;

    typedef enum logic
    {
        CFG_INTERRUPT_MARKER = 1'b0,
        CFG_SKIP_MARKER      = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic        need_pause;
        logic [31:0] delta;
        logic [7:0]  reg_num;
        logic [7:0]  data;
    } cmd_t;

    typedef struct packed
    {
        logic empty;
        logic full;
    } qstat_t;

    typedef enum logic [2:0]
    {
        B_IDLE,
        B_DIV,
        B_SPLIT,
        B_SKIP,
        B_COUNT,
        B_INTR,
        B_REG,
        B_DATA
    } back_state_t;

    // eight quotient bits of a division by five, remainder carried in and out
    function automatic logic [10:0] div5_step(input logic [2:0] rem_in,
                                              input logic [7:0] bits);
        logic [3:0] r;
        logic [7:0] q;
        r = {1'b0, rem_in};
        q = '0;
        for (int i = 7; i >= 0; i--)
        begin
            r = {r[2:0], bits[i]};
            if (r >= 4'd5)
            begin
                r    = r - 4'd5;
                q[i] = 1'b1;
            end
        end
        return {r[2:0], q};
    endfunction

endpackage

// ----- design/psg_register_dump_encoder.sv -----
// top level of the psg register dump encoder: front, queue, back, config registers
// depends on pdenc_pkg, pdenc_front, pdenc_queue, pdenc_back
//
// channel   handshake              payload
// in        in_valid / in_stall    is_register_select, value, timestamp
// out       out_valid / out_stall  out_byte, last
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a data write with a pause takes a pop, four 8-bit division steps by five
// and a split step before its output bytes; without a pause the pop leads straight to the bytes
// the front accepts while the two-entry queue has room; register selects take the same condition
// rst_n clears control state asynchronously; markers reset to 0xFF and 0xFE
// out_stall holds a valid output register and stops the sequencer from emitting
module psg_register_dump_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        is_register_select,
    input  logic [7:0]  value,
    input  logic [31:0] timestamp,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import pdenc_pkg::*;

    logic       push;
    logic       pop;
    cmd_t       push_cmd;
    cmd_t       head;
    qstat_t     qstat;
    logic [7:0] intr_reg;
    logic [7:0] skip_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intr_reg <= IntrReset;
            skip_reg <= SkipReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_INTERRUPT_MARKER: intr_reg <= cfg_data;
                CFG_SKIP_MARKER:      skip_reg <= cfg_data;
                default:              intr_reg <= intr_reg;
            endcase
        end
    end

    pdenc_front u_front
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .is_register_select (is_register_select),
        .value              (value),
        .timestamp          (timestamp),
        .qstat              (qstat),
        .push               (push),
        .cmd                (push_cmd)
    );

    pdenc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    pdenc_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .qstat            (qstat),
        .pop              (pop),
        .interrupt_marker (intr_reg),
        .skip_marker      (skip_reg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .last             (last)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full))
        else $error("request pushed into full queue");

    a_push_reg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_cmd.reg_num < RegLimit))
        else $error("request queued for out-of-range register");

    a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(qstat.full) |-> $past(push))
        else $error("queue filled without a push");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

endmodule

// ----- design/pdenc_front.sv -----
// front part: takes requests, keeps reference time and selected register
// depends on pdenc_pkg
module pdenc_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  is_register_select,
    input  logic [7:0]            value,
    input  logic [31:0]           timestamp,
    input  pdenc_pkg::qstat_t     qstat,
    output logic                  push,
    output pdenc_pkg::cmd_t       cmd
);
    import pdenc_pkg::*;

    logic        have_ref_reg, have_ref_next;
    logic [31:0] ref_time_reg, ref_time_next;
    logic [7:0]  sel_reg, sel_next;
    logic [31:0] ref_eff;
    logic [31:0] delta;
    logic        accept;
    logic        need;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !qstat.full;
    assign ref_eff  = have_ref_reg ? ref_time_reg : timestamp;
    assign delta    = timestamp - ref_eff;
    assign need     = delta > PauseThreshold;
    assign push     = accept && !is_register_select && (sel_reg < RegLimit);

    always_comb
    begin
        cmd.need_pause = need;
        cmd.delta      = delta;
        cmd.reg_num    = sel_reg;
        cmd.data       = value;
    end

    always_comb
    begin
        have_ref_next = have_ref_reg;
        ref_time_next = ref_time_reg;
        sel_next      = sel_reg;
        if (accept)
        begin
            have_ref_next = 1'b1;
            ref_time_next = ref_eff;
            if (is_register_select)
                sel_next = value;
            else if (push && need)
                ref_time_next = timestamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_ref_reg <= 1'b0;
            ref_time_reg <= '0;
            sel_reg      <= SelectReset;
        end
        else
        begin
            have_ref_reg <= have_ref_next;
            ref_time_reg <= ref_time_next;
            sel_reg      <= sel_next;
        end
    end

endmodule

// ----- design/pdenc_queue.sv -----
// two-entry command queue between front and back parts
// depends on pdenc_pkg
module pdenc_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pdenc_pkg::cmd_t   push_cmd,
    input  logic              pop,
    output pdenc_pkg::cmd_t   head,
    output pdenc_pkg::qstat_t qstat
);
    import pdenc_pkg::*;

    cmd_t       mem [QueueDepth];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head        = mem[rd_ptr_reg];
    assign qstat.empty = (count_reg == 2'd0);
    assign qstat.full  = (count_reg == 2'(QueueDepth));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + 1'b1;
        rd_ptr_next = rd_ptr_reg + 1'b1;
        count_next  = count_reg;
        if (!push)
            wr_ptr_next = wr_ptr_reg;
        if (!pop)
            rd_ptr_next = rd_ptr_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/pdenc_back.sv -----
// back part: pause division by twenty and byte sequencer with output register
// depends on pdenc_pkg
module pdenc_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  pdenc_pkg::cmd_t   head,
    input  pdenc_pkg::qstat_t qstat,
    output logic              pop,
    input  logic [7:0]        interrupt_marker,
    input  logic [7:0]        skip_marker,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              last
);
    import pdenc_pkg::*;

    back_state_t state_reg, state_next;
    logic [31:0] div_reg, div_next;
    logic [31:0] quo_reg, quo_next;
    logic [2:0]  rem_reg, rem_next;
    logic [3:0]  low_reg, low_next;
    logic [1:0]  step_reg, step_next;
    logic [1:0]  rest_reg, rest_next;
    logic [7:0]  reg_num_reg, reg_num_next;
    logic [7:0]  data_reg, data_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        last_reg, last_next;

    logic [32:0] sum;
    logic [10:0] step_res;
    logic [6:0]  rem80;
    logic [1:0]  rest_calc;
    logic        emit_valid;
    logic [7:0]  emit_byte;
    logic        emit_last;
    logic        adv;

    assign sum      = {1'b0, head.delta} + {1'b0, PauseThreshold};
    assign step_res = div5_step(rem_reg, div_reg[31:24]);
    assign rem80    = {rem_reg, 4'b0000} + {3'b000, low_reg};
    assign rest_calc = (rem80 >= 7'd60) ? 2'd3 :
                       (rem80 >= 7'd40) ? 2'd2 :
                       (rem80 >= 7'd20) ? 2'd1 : 2'd0;
    assign pop = (state_reg == B_IDLE) && !qstat.empty;
    assign adv = emit_valid && (!out_valid_reg || !out_stall);

    // output decode
    always_comb
    begin
        emit_valid = 1'b1;
        emit_byte  = data_reg;
        emit_last  = 1'b0;
        case (state_reg)
            B_SKIP:  emit_byte = skip_marker;
            B_COUNT: emit_byte = quo_reg[7:0];
            B_INTR:  emit_byte = interrupt_marker;
            B_REG:   emit_byte = reg_num_reg;
            B_DATA:  emit_last = 1'b1;
            default: emit_valid = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (pop)
                    state_next = head.need_pause ? B_DIV : B_REG;
            B_DIV:
                if (step_reg == 2'(DivSteps - 1))
                    state_next = B_SPLIT;
            B_SPLIT:
                state_next = (quo_reg == '0) ? B_INTR : B_SKIP;
            B_SKIP:
                if (adv)
                    state_next = B_COUNT;
            B_COUNT:
                if (adv)
                    state_next = (rest_reg == 2'd0) ? B_REG : B_INTR;
            B_INTR:
                if (adv && rest_reg == 2'd1)
                    state_next = B_REG;
            B_REG:
                if (adv)
                    state_next = B_DATA;
            B_DATA:
                if (adv)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        div_next     = div_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        low_next     = low_reg;
        step_next    = step_reg;
        rest_next    = rest_reg;
        reg_num_next = reg_num_reg;
        data_next    = data_reg;
        case (state_reg)
            B_IDLE:
                if (pop)
                begin
                    div_next     = {3'b000, sum[32:4]};
                    low_next     = sum[3:0];
                    quo_next     = '0;
                    rem_next     = '0;
                    step_next    = '0;
                    reg_num_next = head.reg_num;
                    data_next    = head.data;
                end
            B_DIV:
            begin
                div_next  = {div_reg[23:0], 8'h00};
                quo_next  = {quo_reg[23:0], step_res[7:0]};
                rem_next  = step_res[10:8];
                step_next = step_reg + 2'd1;
            end
            B_SPLIT:
                rest_next = rest_calc;
            B_INTR:
                if (adv)
                    rest_next = rest_reg - 2'd1;
            default:
                rest_next = rest_reg;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            last_next      = emit_last;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        div_reg      <= div_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        low_reg      <= low_next;
        step_reg     <= step_next;
        rest_reg     <= rest_next;
        reg_num_reg  <= reg_num_next;
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule

// ----- dv/dump_stream_checker.sv -----
// checker for the psg register dump encoder: watches the write, dump and marker channels
// predicts the dump bytes of every write request and compares them in order
// depends on pdenc_pkg
module dump_stream_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       is_register_select,
    input  logic [7:0] value,
    input  logic [31:0] timestamp,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       last,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending
);

    import pdenc_pkg::*;

    localparam logic [32:0] FrameUnits  = 33'd20;
    localparam logic [32:0] BlockFrames = 33'd4;

    typedef struct packed
    {
        logic [7:0] code;
        logic       is_last;
    } dump_byte_t;

    dump_byte_t  expected_bytes[$];
    logic        ref_valid;
    logic [31:0] ref_time;
    logic [7:0]  cur_reg;
    logic [7:0]  intr_code;
    logic [7:0]  skip_code;
    int          errs;

    function automatic void push_byte(input logic [7:0] code, input logic is_last);
        dump_byte_t entry;
        entry.code    = code;
        entry.is_last = is_last;
        expected_bytes.push_back(entry);
    endfunction

    function automatic void encode_write(input logic sel, input logic [7:0] val,
                                         input logic [31:0] ts);
        logic [31:0] delta;
        logic [32:0] pause;
        logic [32:0] blocks;
        logic [1:0]  tail;
        int          k;
        if (!ref_valid)
        begin
            ref_time  = ts;
            ref_valid = 1'b1;
        end
        if (sel)
        begin
            cur_reg = val;
            return;
        end
        if (cur_reg >= RegLimit)
            return;
        delta = ts - ref_time;
        if (delta > PauseThreshold)
        begin
            // widened so that a delta near the top does not wrap
            pause  = ({1'b0, delta} + {1'b0, PauseThreshold}) / FrameUnits;
            blocks = pause / BlockFrames;
            tail   = 2'(pause % BlockFrames);
            if (pause >= BlockFrames)
            begin
                push_byte(skip_code, 1'b0);
                push_byte(blocks[7:0], 1'b0);
            end
            for (k = 0; k < int'(tail); k++)
                push_byte(intr_code, 1'b0);
            ref_time = ts;
        end
        push_byte(cur_reg, 1'b0);
        push_byte(val, 1'b1);
    endfunction

    function automatic void check_byte();
        dump_byte_t want;
        if (expected_bytes.size() == 0)
        begin
            $error("out_byte expected none actual 0x%02h", out_byte);
            errs++;
            return;
        end
        want = expected_bytes.pop_front();
        if (out_byte !== want.code)
        begin
            $error("out_byte expected 0x%02h actual 0x%02h", want.code, out_byte);
            errs++;
        end
        if (last !== want.is_last)
        begin
            $error("last expected %0b actual %0b", want.is_last, last);
            errs++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_valid = 1'b0;
            ref_time  = '0;
            cur_reg   = SelectReset;
            intr_code = IntrReset;
            skip_code = SkipReset;
            errs      = 0;
            expected_bytes.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_INTERRUPT_MARKER: intr_code = cfg_data;
                    CFG_SKIP_MARKER:      skip_code = cfg_data;
                    default:              ;
                endcase
            end
            if (in_valid && !in_stall)
                encode_write(is_register_select, value, timestamp);
            if (out_valid && !out_stall)
                check_byte();
            pending    <= expected_bytes.size();
            fail_count <= errs;
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// top of the psg register dump encoder testbench: clock, reset, write and dump stimulus
// marker register phases, watchdog and verdict
// depends on pdenc_pkg, psg_register_dump_encoder, dump_stream_checker
module tb_top;

    import pdenc_pkg::*;

    localparam int Settle     = 16;
    localparam int StallLimit = 2000;
    localparam int HoldCycles = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        is_register_select = 1'b0;
    logic [7:0]  value = '0;
    logic [31:0] timestamp = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = '0;
    int          fail_count;
    int          pending;

    logic        quiet = 1'b0;
    logic        squeeze = 1'b0;
    logic [31:0] now_ts = '0;
    int          idle_cycles = 0;

    always #1 clk = ~clk;

    psg_register_dump_encoder dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .is_register_select (is_register_select),
        .value              (value),
        .timestamp          (timestamp),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .out_byte           (out_byte),
        .last               (last),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    dump_stream_checker stream_check
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .is_register_select (is_register_select),
        .value              (value),
        .timestamp          (timestamp),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .out_byte           (out_byte),
        .last               (last),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    task automatic send_write(input logic sel, input logic [7:0] val, input logic [31:0] ts);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid           <= 1'b1;
        is_register_select <= sel;
        value              <= val;
        timestamp          <= ts;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // data write whose timestamp moves on from the last one
    task automatic send_data_after(input logic [7:0] val, input logic [31:0] step);
        now_ts = now_ts + step;
        send_write(1'b0, val, now_ts);
    endtask

    task automatic random_item();
        int          pick;
        logic [31:0] step;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            if ($urandom_range(0, 4) == 0)
                send_write(1'b1, 8'($urandom_range(18, 255)), $urandom);
            else
                send_write(1'b1, 8'($urandom_range(0, 17)), $urandom);
        end
        else if (pick < 22)
        begin
            now_ts = $urandom;
            send_write(1'b0, 8'($urandom), now_ts);
        end
        else
        begin
            case ($urandom_range(0, 5))
                0:       step = $urandom_range(0, 10);
                1:       step = $urandom_range(11, 89);
                2:       step = $urandom_range(90, 400);
                3:       step = $urandom_range(20400, 20600);
                4:       step = $urandom_range(401, 1 << 20);
                default: step = $urandom;
            endcase
            send_data_after(8'($urandom), step);
        end
    endtask

    task automatic write_markers(input logic [7:0] intr, input logic [7:0] skip);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INTERRUPT_MARKER;
        cfg_data  <= intr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_SKIP_MARKER;
        cfg_data  <= skip;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (Settle) @(posedge clk);
    endtask

    // dump side stalls, with one long hold so that the encoder backs up
    initial
    begin
        forever
        begin
            if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (squeeze)
            begin
                out_stall <= 1'b1;
                repeat (HoldCycles) @(posedge clk);
                squeeze = 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == StallLimit)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset markers; first request sets the reference with no register selected
        now_ts = 32'd1000;
        send_write(1'b0, 8'h5A, now_ts);
        send_write(1'b1, 8'h00, 32'h0000_0007);
        send_data_after(8'h00, 32'd10);
        send_data_after(8'hFF, 32'd1);
        send_write(1'b1, 8'd17, 32'h0000_0000);
        send_data_after(8'h81, 32'd69);
        send_data_after(8'h7E, 32'd70);
        send_data_after(8'h33, 32'd149);
        // data writes to registers at or above the limit leave the reference time alone and queue nothing
        send_write(1'b1, 8'd18, 32'hFFFF_FFFF);
        send_write(1'b0, 8'h44, 32'hFFFF_FFFF);
        send_write(1'b1, 8'hFF, 32'h0000_0000);
        send_write(1'b0, 8'h55, 32'h0000_0000);
        send_write(1'b1, 8'hAA, 32'hAAAA_AAAA);
        send_write(1'b1, 8'h55, 32'h5555_5555);
        send_write(1'b1, 8'h01, 32'h0000_0000);
        // block count at 255, then wrapping to zero
        send_data_after(8'hAA, 32'd20469);
        send_data_after(8'h55, 32'd20470);
        // largest delta
        send_data_after(8'h0F, 32'hFFFF_FFFF);
        now_ts = 32'h0000_0000;
        send_write(1'b0, 8'hF0, now_ts);
        now_ts = 32'hFFFF_FFFF;
        send_write(1'b0, 8'h0F, now_ts);
        send_write(1'b1, 8'd5, 32'h0000_0000);
        send_data_after(8'h3C, 32'd5);
        send_data_after(8'hC3, 32'd11);
        drain();

        write_markers(8'h00, 8'hFF);
        repeat (65) random_item();
        drain();

        write_markers(8'hFF, 8'h00);
        repeat (30) random_item();
        squeeze = 1'b1;
        send_write(1'b1, 8'd3, $urandom);
        repeat (20) send_data_after(8'($urandom), 32'($urandom_range(0, 200)));
        repeat (20) random_item();
        drain();

        write_markers(8'($urandom), 8'($urandom));
        repeat (40) random_item();
        quiet = 1'b1;
        repeat (40) random_item();
        drain();

        if (pending != 0)
            $error("%0d expected dump bytes never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pdenc_pkg.sv
design/pdenc_front.sv
design/pdenc_queue.sv
design/pdenc_back.sv
design/psg_register_dump_encoder.sv
dv/dump_stream_checker.sv
dv/tb_top.sv
